@@ sv/dhcp6opt_pkg.sv @@
package dhcp6opt_pkg;

   localparam logic [1:0] KIND_CLIENT_ID = 2'd0;
   localparam logic [1:0] KIND_SERVER_ID = 2'd1;
   localparam logic [1:0] KIND_IA_PD     = 2'd2;
   localparam logic [1:0] KIND_OTHER     = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
   localparam logic [1:0] STATUS_WRONG_TYPE = 2'd2;

   localparam logic [7:0] MSG_ADVERTISE = 8'd2;
   localparam logic [7:0] MSG_REPLY     = 8'd7;

   localparam logic [15:0] OPT_CLIENT_ID = 16'd1;
   localparam logic [15:0] OPT_SERVER_ID = 16'd2;
   localparam logic [15:0] OPT_IA_PD     = 16'd25;

   localparam logic [1:0] HDR_LAST_INDEX = 2'd3;

   typedef enum logic [3:0] {
      PHASE_HEADER  = 4'b0001,
      PHASE_OPTHDR  = 4'b0010,
      PHASE_PAYLOAD = 4'b0100,
      PHASE_SKIP    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic        is_final;
      logic [1:0]  option_kind;
      logic [15:0] option_code;
      logic [15:0] option_length;
      logic [15:0] option_offset;
      logic [1:0]  parse_status;
      logic        truncated;
      logic [7:0]  message_type;
      logic [23:0] transaction_id;
      logic [15:0] prefix_option_count;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  hdr_index;
      logic [15:0] code;
      logic [15:0] length;
      logic [15:0] remaining;
      logic [7:0]  msg_type;
      logic [23:0] xid;
      logic [15:0] prefix_count;
   } parse_state_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

@@ sv/dhcp6opt_step.sv @@
module dhcp6opt_step
   import dhcp6opt_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  parse_state_type        state_cur,
   input  logic [OFFSET_BITS-1:0] position_cur,
   input  logic [OFFSET_BITS-1:0] start_cur,
   input  req_type                beat,
   output parse_state_type        state_nxt,
   output logic [OFFSET_BITS-1:0] position_nxt,
   output logic [OFFSET_BITS-1:0] start_nxt,
   output push_type               push,
   output rsp_type                result_a,
   output rsp_type                result_b
);

   localparam logic [OFFSET_BITS-1:0] POS_LIMIT = {OFFSET_BITS{1'b1}};

   parse_state_type        upd;
   logic [OFFSET_BITS-1:0] start_upd;
   logic                   fin;
   logic                   rec;
   logic [1:0]             status;
   logic                   trunc;
   logic [1:0]             kind;
   logic [15:0]            rem_dec;
   rsp_type                record_item;
   rsp_type                final_item;

   always_comb begin
      upd       = state_cur;
      start_upd = start_cur;
      fin       = 1'b0;
      rec       = 1'b0;
      status    = STATUS_OK;
      trunc     = 1'b0;
      kind      = KIND_OTHER;
      rem_dec   = state_cur.remaining;
      case (state_cur.phase)
         PHASE_HEADER: begin
            if (state_cur.hdr_index == 2'd0) begin
               upd.msg_type = beat.data_byte;
            end else begin
               upd.xid = {state_cur.xid[15:0], beat.data_byte};
            end
            if (beat.end_of_message) begin
               fin    = 1'b1;
               status = STATUS_TOO_SHORT;
            end else if (state_cur.hdr_index == HDR_LAST_INDEX) begin
               upd.hdr_index = 2'd0;
               if (upd.msg_type == MSG_ADVERTISE || upd.msg_type == MSG_REPLY) begin
                  upd.phase = PHASE_OPTHDR;
               end else begin
                  upd.phase = PHASE_SKIP;
               end
            end else begin
               upd.hdr_index = state_cur.hdr_index + 2'd1;
            end
         end
         PHASE_OPTHDR: begin
            if (state_cur.hdr_index == 2'd0) begin
               start_upd = position_cur;
            end
            if (!state_cur.hdr_index[1]) begin
               upd.code = {state_cur.code[7:0], beat.data_byte};
            end else begin
               upd.length = {state_cur.length[7:0], beat.data_byte};
            end
            if (state_cur.hdr_index == HDR_LAST_INDEX) begin
               rec = 1'b1;
               if (state_cur.code == OPT_CLIENT_ID) begin
                  kind = KIND_CLIENT_ID;
               end else if (state_cur.code == OPT_SERVER_ID) begin
                  kind = KIND_SERVER_ID;
               end else if (state_cur.code == OPT_IA_PD) begin
                  kind = KIND_IA_PD;
                  if (state_cur.prefix_count != 16'hFFFF) begin
                     upd.prefix_count = state_cur.prefix_count + 16'd1;
                  end
               end
               upd.hdr_index = 2'd0;
               upd.remaining = upd.length;
               upd.phase     = (upd.length != 16'd0) ? PHASE_PAYLOAD : PHASE_OPTHDR;
               if (beat.end_of_message) begin
                  fin   = 1'b1;
                  trunc = (upd.length != 16'd0);
               end
            end else begin
               upd.hdr_index = state_cur.hdr_index + 2'd1;
               if (beat.end_of_message) begin
                  fin   = 1'b1;
                  trunc = 1'b1;
               end
            end
         end
         PHASE_PAYLOAD: begin
            if (state_cur.remaining != 16'd0) begin
               rem_dec = state_cur.remaining - 16'd1;
            end
            upd.remaining = rem_dec;
            if (rem_dec == 16'd0) begin
               upd.phase = PHASE_OPTHDR;
            end
            if (beat.end_of_message) begin
               fin   = 1'b1;
               trunc = (rem_dec != 16'd0);
            end
         end
         default: begin
            if (beat.end_of_message) begin
               fin    = 1'b1;
               status = STATUS_WRONG_TYPE;
            end
         end
      endcase
   end

   always_comb begin
      record_item                     = '0;
      record_item.option_kind         = kind;
      record_item.option_code         = state_cur.code;
      record_item.option_length       = upd.length;
      record_item.option_offset       = 16'(start_upd);
      record_item.message_type        = upd.msg_type;
      record_item.transaction_id      = upd.xid;
      record_item.prefix_option_count = upd.prefix_count;

      final_item                     = '0;
      final_item.is_final            = 1'b1;
      final_item.parse_status        = status;
      final_item.truncated           = trunc;
      final_item.message_type        = upd.msg_type;
      final_item.transaction_id      = upd.xid;
      final_item.prefix_option_count = upd.prefix_count;
   end

   always_comb begin
      push.first  = rec | fin;
      push.second = rec & fin;
      result_a    = rec ? record_item : final_item;
      result_b    = final_item;
      if (fin) begin
         state_nxt       = '0;
         state_nxt.phase = PHASE_HEADER;
         start_nxt       = '0;
         position_nxt    = '0;
      end else begin
         state_nxt    = upd;
         start_nxt    = start_upd;
         position_nxt = (position_cur != POS_LIMIT) ? position_cur + 1'b1 : position_cur;
      end
   end

endmodule

@@ sv/dhcp6opt_queue.sv @@
module dhcp6opt_queue
   import dhcp6opt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  rsp_type  result_a,
   input  rsp_type  result_b,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   localparam int DEPTH = 4;

   rsp_type    slot_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] wr_next;
   logic       pop;
   logic [1:0] push_n;

   assign wr_next     = wr_ptr_ff + 2'd1;
   assign pop         = rsp_valid & rsp_ready;
   assign push_n      = {1'b0, push.first} + {1'b0, push.second};
   assign room        = (count_ff <= 3'd2);
   assign rsp_valid   = (count_ff != 3'd0);
   assign rsp_payload = slot_ff[rd_ptr_ff];
   assign wr_ptr_in   = wr_ptr_ff + push_n;
   assign rd_ptr_in   = rd_ptr_ff + {1'b0, pop};
   assign count_in    = count_ff + {1'b0, push_n} - {2'b0, pop};

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (push.first && wr_ptr_ff == 2'(i)) begin
            slot_ff[i] <= result_a;
         end else if (push.second && wr_next == 2'(i)) begin
            slot_ff[i] <= result_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4) else $error("queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.first |-> room) else $error("push into queue without room");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.second |-> push.first) else $error("second result without first");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff != 3'd4 |-> (wr_ptr_ff - rd_ptr_ff) == count_ff[1:0])
      else $error("queue pointers disagree with count");

endmodule

@@ sv/dhcpv6_option_tlv_parser.sv @@
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_payload (req_type): one message byte
// rsp      out        rsp_valid/rsp_ready  rsp_payload (rsp_type): option record or status
//
// Each byte is parsed in the cycle it is accepted; one byte per cycle while req_ready is high.
// A byte yields up to two beats, which enter a four-entry output queue that drains one beat
// per cycle while rsp_ready is high; req_ready is low while fewer than two entries are free.
// Reset returns the parser to the message header and empties the queue.
module dhcpv6_option_tlv_parser
   import dhcp6opt_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam parse_state_type STATE_RESET = '{
      phase:        PHASE_HEADER,
      hdr_index:    2'd0,
      code:         16'd0,
      length:       16'd0,
      remaining:    16'd0,
      msg_type:     8'd0,
      xid:          24'd0,
      prefix_count: 16'd0
   };

   parse_state_type        state_ff, state_in;
   logic [OFFSET_BITS-1:0] position_ff, position_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   push_type               step_push;
   push_type               push;
   rsp_type                result_a;
   rsp_type                result_b;
   logic                   room;
   logic                   accept;

   assign req_ready   = room;
   assign accept      = req_valid & room;
   assign push.first  = accept & step_push.first;
   assign push.second = accept & step_push.second;

   dhcp6opt_step #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_step (
      .state_cur   (state_ff),
      .position_cur(position_ff),
      .start_cur   (start_ff),
      .beat        (req_payload),
      .state_nxt   (state_in),
      .position_nxt(position_in),
      .start_nxt   (start_in),
      .push        (step_push),
      .result_a    (result_a),
      .result_b    (result_b)
   );

   dhcp6opt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .result_a   (result_a),
      .result_b   (result_b),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= STATE_RESET;
         position_ff <= '0;
         start_ff    <= '0;
      end else if (accept) begin
         state_ff    <= state_in;
         position_ff <= position_in;
         start_ff    <= start_in;
      end
   end

   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.end_of_message |=> state_ff.phase == PHASE_HEADER
      && position_ff == '0) else $error("parser not back at header after last byte");

   a_header_index: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PHASE_PAYLOAD |-> state_ff.hdr_index == 2'd0 &&
      state_ff.remaining != 16'd0) else $error("payload phase with bad counters");

   a_skip_no_record: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff.phase == PHASE_SKIP |-> !step_push.second &&
      step_push.first == req_payload.end_of_message)
      else $error("record produced while skipping");

endmodule

@@ bench/dhcp6opt_checker.sv @@
`timescale 1ns / 1ps

module dhcp6opt_checker
   import dhcp6opt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending_count,
   output int      beats_checked
);

   localparam logic [15:0] POSITION_MAX = 16'hFFFF;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   rsp_type     rsp_expected[$];

   logic [15:0] position;
   phase_type   phase;
   logic [1:0]  hdr_idx;
   logic [15:0] code_acc;
   logic [15:0] length_acc;
   logic [15:0] payload_left;
   logic [15:0] option_start;
   logic [7:0]  msg_type;
   logic [23:0] xid;
   logic [15:0] prefix_count;

   task automatic clear_parse();
      position     = '0;
      phase        = PHASE_HEADER;
      hdr_idx      = '0;
      code_acc     = '0;
      length_acc   = '0;
      payload_left = '0;
      option_start = '0;
      msg_type     = '0;
      xid          = '0;
      prefix_count = '0;
   endtask

   function automatic rsp_type make_beat(input logic fin, input logic [1:0] kind,
                                         input logic [15:0] code_v, input logic [15:0] len_v,
                                         input logic [15:0] off_v, input logic [1:0] status,
                                         input logic trunc);
      rsp_type r;
      r.is_final            = fin;
      r.option_kind         = kind;
      r.option_code         = code_v;
      r.option_length       = len_v;
      r.option_offset       = off_v;
      r.parse_status        = status;
      r.truncated           = trunc;
      r.message_type        = msg_type;
      r.transaction_id      = xid;
      r.prefix_option_count = prefix_count;
      return r;
   endfunction

   function automatic string beat_text(input rsp_type r);
      return {$sformatf("final=%0d kind=%0d code=%h len=%h off=%h status=%0d trunc=%0d",
                        r.is_final, r.option_kind, r.option_code, r.option_length,
                        r.option_offset, r.parse_status, r.truncated),
              $sformatf(" type=%h xid=%h count=%0d",
                        r.message_type, r.transaction_id, r.prefix_option_count)};
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic last);
      logic       fin;
      logic [1:0] status;
      logic       trunc;
      logic [1:0] kind;
      fin    = 1'b0;
      status = STATUS_OK;
      trunc  = 1'b0;
      kind   = KIND_OTHER;
      case (phase)
         PHASE_HEADER: begin
            if (hdr_idx == 2'd0) begin
               msg_type = b;
            end else begin
               xid = {xid[15:0], b};
            end
            if (last) begin
               fin    = 1'b1;
               status = STATUS_TOO_SHORT;
            end else if (hdr_idx == HDR_LAST_INDEX) begin
               hdr_idx = '0;
               phase   = (msg_type == MSG_ADVERTISE || msg_type == MSG_REPLY) ?
                         PHASE_OPTHDR : PHASE_SKIP;
            end else begin
               hdr_idx++;
            end
         end
         PHASE_OPTHDR: begin
            if (hdr_idx == 2'd0) begin
               option_start = position;
            end
            if (hdr_idx < 2'd2) begin
               code_acc = {code_acc[7:0], b};
            end else begin
               length_acc = {length_acc[7:0], b};
            end
            if (hdr_idx == HDR_LAST_INDEX) begin
               if (code_acc == OPT_CLIENT_ID) begin
                  kind = KIND_CLIENT_ID;
               end else if (code_acc == OPT_SERVER_ID) begin
                  kind = KIND_SERVER_ID;
               end else if (code_acc == OPT_IA_PD) begin
                  kind = KIND_IA_PD;
                  if (prefix_count != COUNT_MAX) begin
                     prefix_count++;
                  end
               end
               rsp_expected.push_back(make_beat(1'b0, kind, code_acc, length_acc,
                                                option_start, STATUS_OK, 1'b0));
               hdr_idx      = '0;
               payload_left = length_acc;
               phase        = (length_acc != 16'd0) ? PHASE_PAYLOAD : PHASE_OPTHDR;
               if (last) begin
                  fin   = 1'b1;
                  trunc = (length_acc != 16'd0);
               end
            end else begin
               hdr_idx++;
               if (last) begin
                  fin   = 1'b1;
                  trunc = 1'b1;
               end
            end
         end
         PHASE_PAYLOAD: begin
            if (payload_left != 16'd0) begin
               payload_left--;
            end
            if (payload_left == 16'd0) begin
               phase = PHASE_OPTHDR;
            end
            if (last) begin
               fin   = 1'b1;
               trunc = (payload_left != 16'd0);
            end
         end
         default: begin
            if (last) begin
               fin    = 1'b1;
               status = STATUS_WRONG_TYPE;
            end
         end
      endcase
      if (fin) begin
         rsp_expected.push_back(make_beat(1'b1, KIND_CLIENT_ID, '0, '0, '0, status, trunc));
         clear_parse();
      end else if (position != POSITION_MAX) begin
         position++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_parse();
         rsp_expected.delete();
      end else begin
         // Result beats are taken before the byte of this edge, whose beats come later.
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (rsp_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected beat: %s", beat_text(rsp_payload));
               end
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_payload !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("beat %0d differs", beats_checked);
                     $display("   expected %s", beat_text(want));
                     $display("   actual   %s", beat_text(rsp_payload));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_byte(req_payload.data_byte, req_payload.end_of_message);
         end
      end
      pending_count <= rsp_expected.size();
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import dhcp6opt_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_BYTES = 360;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_BURSTY
   } ready_mode_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int beats_checked;

   ready_mode_type ready_mode = READY_ALWAYS;
   logic [15:0]    ready_cycle = '0;
   int             ready_hold  = 0;
   int             idle_cycles = 0;

   logic [7:0] msg_bytes[$];
   int         burst_left     = 0;
   int         messages_sent  = 0;
   int         bytes_sent     = 0;
   int         directed_count = 0;

   dhcpv6_option_tlv_parser #(.OFFSET_BITS(16)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   dhcp6opt_checker option_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .beats_checked (beats_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         ready_cycle <= '0;
         ready_hold  <= 0;
      end else begin
         ready_cycle <= ready_cycle + 16'd1;
         if (ready_cycle[6:0] == 7'd0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
         end
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= (ready_cycle[1:0] == 2'b00);
            default: begin
               if (ready_hold != 0) begin
                  ready_hold <= ready_hold - 1;
                  rsp_ready  <= 1'b0;
               end else begin
                  ready_hold <= $urandom_range(0, 15);
                  rsp_ready  <= 1'b1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("dhcpv6_option_tlv_parser: mismatch");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic eom);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: d, end_of_message: eom};
      @(negedge clock);
      while (!req_ready) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic start_message(input logic [7:0] mtype, input logic [23:0] tid);
      msg_bytes.delete();
      msg_bytes.push_back(mtype);
      msg_bytes.push_back(tid[23:16]);
      msg_bytes.push_back(tid[15:8]);
      msg_bytes.push_back(tid[7:0]);
   endtask

   task automatic add_option(input logic [15:0] code, input logic [15:0] len, input int fill);
      msg_bytes.push_back(code[15:8]);
      msg_bytes.push_back(code[7:0]);
      msg_bytes.push_back(len[15:8]);
      msg_bytes.push_back(len[7:0]);
      repeat (fill) msg_bytes.push_back(8'($urandom));
   endtask

   task automatic cut_message(input int keep);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++) begin
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      end
      messages_sent++;
      bytes_sent += msg_bytes.size();
   endtask

   function automatic logic [15:0] pick_code();
      case ($urandom_range(0, 3))
         0:       return OPT_CLIENT_ID;
         1:       return OPT_SERVER_ID;
         2:       return OPT_IA_PD;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int random_bytes;
      int sel;
      int n_opt;
      int len;
      logic [7:0] mtype;
      random_bytes = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Messages that end within the header.
      start_message(8'hFF, 24'hFFFFFF); cut_message(1); send_message();
      start_message(MSG_REPLY, 24'h000000); cut_message(2); send_message();
      start_message(8'h00, 24'hABCDEF); cut_message(3); send_message();
      start_message(MSG_ADVERTISE, 24'hFFFFFF); send_message();
      start_message(8'h05, 24'h123456); send_message();

      // Wrong message types followed by further bytes.
      start_message(8'h00, 24'h0000FF); add_option(OPT_IA_PD, 16'd0, 0); send_message();
      start_message(8'hFF, 24'h800001); msg_bytes.push_back(8'hFF); send_message();
      start_message(8'h03, 24'h7FFFFE); add_option(OPT_CLIENT_ID, 16'd3, 3); send_message();

      // A zero-length option header on the final byte, then one with a length.
      start_message(MSG_REPLY, 24'h000001); add_option(OPT_CLIENT_ID, 16'd0, 0); send_message();
      start_message(MSG_ADVERTISE, 24'($urandom)); add_option(OPT_SERVER_ID, 16'd1, 0);
      send_message();

      // Every kind of option, with extreme codes.
      start_message(MSG_REPLY, 24'($urandom));
      add_option(OPT_CLIENT_ID, 16'd3, 3);
      add_option(OPT_SERVER_ID, 16'd2, 2);
      add_option(OPT_IA_PD, 16'd1, 1);
      add_option(16'h0000, 16'd0, 0);
      add_option(16'hFFFF, 16'd4, 4);
      add_option(16'h1900, 16'd0, 0);
      add_option(16'h0100, 16'h0002, 2);
      send_message();

      // Endings inside an option header, and inside a long payload.
      for (int k = 1; k <= 3; k++) begin
         start_message(MSG_ADVERTISE, 24'($urandom));
         add_option(16'hFFFF, 16'hFFFF, 0);
         cut_message(4 + k);
         send_message();
      end
      start_message(MSG_REPLY, 24'($urandom)); add_option(OPT_IA_PD, 16'hFFFF, 5); send_message();

      start_message(MSG_ADVERTISE, 24'($urandom)); add_option(OPT_SERVER_ID, 16'd1, 1);
      send_message();
      directed_count = messages_sent;

      while (random_bytes < RANDOM_BYTES) begin
         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            mtype = ($urandom_range(0, 1) == 0) ? MSG_ADVERTISE : MSG_REPLY;
            start_message(mtype, 24'($urandom));
            n_opt = $urandom_range(1, 4);
            repeat (n_opt) begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
               add_option(pick_code(), 16'(len), len);
            end
            if ($urandom_range(0, 3) == 0) begin
               cut_message($urandom_range(1, msg_bytes.size() - 1));
            end
         end else if (sel < 9) begin
            start_message(8'($urandom), 24'($urandom));
            cut_message($urandom_range(1, 4));
            repeat ($urandom_range(0, 20)) msg_bytes.push_back(8'($urandom));
         end else begin
            mtype = ($urandom_range(0, 1) == 0) ? MSG_ADVERTISE : MSG_REPLY;
            start_message(mtype, 24'($urandom));
            repeat ($urandom_range(1, 20)) msg_bytes.push_back(8'($urandom));
         end
         random_bytes += msg_bytes.size();
         send_message();
      end
      req_valid <= 1'b0;

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);

      $display("Run covered %0d messages (%0d directed), %0d bytes, sent in gapped bursts",
               messages_sent, directed_count, bytes_sent);
      $display("against four receiver stall patterns; %0d result beats checked, %0d failures.",
               beats_checked, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("dhcpv6_option_tlv_parser: match");
      end else begin
         $display("dhcpv6_option_tlv_parser: mismatch");
      end
      $finish;
   end

endmodule

@@ dhcpv6_option_tlv_parser.f @@
sv/dhcp6opt_pkg.sv
sv/dhcp6opt_step.sv
sv/dhcp6opt_queue.sv
sv/dhcpv6_option_tlv_parser.sv
bench/dhcp6opt_checker.sv
bench/testbench.sv
